@@ rtl/core/decimal_hex_integer_text_parser_top_assert.svh @@
// Assertion macros for the checker file of the text parser.
`ifndef DECIMAL_HEX_INTEGER_TEXT_PARSER_TOP_ASSERT_SVH
`define DECIMAL_HEX_INTEGER_TEXT_PARSER_TOP_ASSERT_SVH

// Check a property on every rising clock edge; skip while reset is held.
`define DHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies another one in the next cycle.
`define DHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dhp_pkg.sv @@
// Types, constants and helpers for the decimal/hex text parser.
`timescale 1ns / 1ps
`default_nettype none

package dhp_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned ACC_W  = 33;
  localparam int unsigned PROD_W = ACC_W + 4;
  localparam int unsigned VAL_W  = 64;

  // Characters the parser reacts to
  localparam logic [CP_W-1:0] CH_SPACE  = CP_W'(32'h20);
  localparam logic [CP_W-1:0] CH_PLUS   = CP_W'(32'h2B);
  localparam logic [CP_W-1:0] CH_MINUS  = CP_W'(32'h2D);
  localparam logic [CP_W-1:0] CH_DOLLAR = CP_W'(32'h24);
  localparam logic [CP_W-1:0] CH_ZERO   = CP_W'(32'h30);
  localparam logic [CP_W-1:0] CH_NINE   = CP_W'(32'h39);
  localparam logic [CP_W-1:0] CH_UP_A   = CP_W'(32'h41);
  localparam logic [CP_W-1:0] CH_UP_F   = CP_W'(32'h46);
  localparam logic [CP_W-1:0] CH_LO_A   = CP_W'(32'h61);
  localparam logic [CP_W-1:0] CH_LO_F   = CP_W'(32'h66);
  localparam logic [CP_W-1:0] CH_UP_X   = CP_W'(32'h58);
  localparam logic [CP_W-1:0] CH_LO_X   = CP_W'(32'h78);

  localparam logic [4:0] DIGIT_NONE = 5'd16;
  localparam logic [4:0] BASE_DEC   = 5'd10;
  localparam logic [4:0] BASE_HEX   = 5'd16;

  localparam logic [PROD_W-1:0] LIMIT_DEC_POS = PROD_W'(64'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] LIMIT_DEC_NEG = PROD_W'(64'h8000_0000);
  localparam logic [PROD_W-1:0] LIMIT_HEX     = PROD_W'(64'hFFFF_FFFF);

  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_BASE   = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } dhp_phase_e;

  typedef struct packed {
    logic [CP_W-1:0]         code_point;
    logic                    has_char;
    logic                    last;
    logic signed [VAL_W-1:0] fallback_value;
  } dhp_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    used_fallback;
  } dhp_out_t;

  typedef struct packed {
    dhp_phase_e       phase;
    logic             neg;
    logic             hex;
    logic [ACC_W-1:0] acc;
    logic             failed;
    logic             seen;
  } dhp_state_t;

  localparam dhp_state_t STATE_RST = '{
    phase:  PH_SPACE,
    neg:    1'b0,
    hex:    1'b0,
    acc:    '0,
    failed: 1'b0,
    seen:   1'b0
  };

  // Digit value of a character, DIGIT_NONE if it is no hex digit.
  function automatic logic [4:0] digit_of(input logic [CP_W-1:0] c);
    logic [CP_W-1:0] off;
    off = '0;
    digit_of = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      off = c - CH_ZERO;
      digit_of = off[4:0];
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      off = c - CH_UP_A;
      digit_of = off[4:0] + 5'd10;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      off = c - CH_LO_A;
      digit_of = off[4:0] + 5'd10;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/decimal_hex_integer_text_parser_top.sv @@
// Top level of the decimal/hex integer text parser.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+------------------------------
//   in      | request   | in_valid_i/in_ready_o | in_req_i   (dhp_in_t)
//   out     | response  | out_valid_o/out_ready_i | out_rsp_o (dhp_out_t)
//
// One character per cycle unless stalled as below: a request is held in
// the input register, then the parse step updates the parser state from it
// in a single pass. A request with last set also loads the response register
// at the end of that step, so the response shows after the input register.
// Reset clears the parser state and both valid flags; no clearing pass.
// A last request held in the input register waits while the response
// register holds a response that is not taken in that cycle; new requests
// stall behind it.
`timescale 1ns / 1ps
`default_nettype none

module decimal_hex_integer_text_parser_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  dhp_pkg::dhp_in_t   in_req_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output dhp_pkg::dhp_out_t  out_rsp_o
);
  import dhp_pkg::*;

  // Input register
  logic       in_valid_q, in_valid_d;
  dhp_in_t    in_req_q;

  // Parser state
  dhp_state_t state_q, state_d;
  dhp_state_t step_nxt;

  // Response register
  logic       out_valid_q, out_valid_d;
  dhp_out_t   out_rsp_q;
  dhp_out_t   step_rsp;

  logic       out_free;
  logic       advance;
  logic       accept;

  dhp_step u_step (
    .cur_i (state_q),
    .req_i (in_req_q),
    .nxt_o (step_nxt),
    .rsp_o (step_rsp)
  );

  // Response slot is free if empty or drained this cycle
  assign out_free = !out_valid_q || out_ready_i;
  // Advance the held request; a last request needs a free response slot
  assign advance  = in_valid_q && (!in_req_q.last || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Drop back to the reset state after each string ends
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = in_req_q.last ? STATE_RST : step_nxt;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_req_q.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RST;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers: input on accept, response when a last request advances; hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q <= in_req_i;
    end
    if (advance && in_req_q.last) begin
      out_rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

@@ rtl/core/dhp_step.sv @@
// Per-character parse step: next parser state and the end-of-string result.
`timescale 1ns / 1ps
`default_nettype none

module dhp_step (
  input  dhp_pkg::dhp_state_t cur_i,
  input  dhp_pkg::dhp_in_t    req_i,
  output dhp_pkg::dhp_state_t nxt_o,
  output dhp_pkg::dhp_out_t   rsp_o
);
  import dhp_pkg::*;

  logic [CP_W-1:0]          c;
  logic [4:0]               digit;
  logic [4:0]               base;
  logic [PROD_W-1:0]        limit;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        sum;
  logic                     dig_bad;
  logic                     take_dig;
  dhp_state_t               nxt;
  logic                     fail;
  logic signed [ACC_W-1:0]  mag;
  logic signed [VAL_W-1:0]  val;

  assign c     = req_i.code_point;
  assign digit = digit_of(c);
  assign base  = cur_i.hex ? BASE_HEX : BASE_DEC;
  assign limit = cur_i.hex ? LIMIT_HEX : (cur_i.neg ? LIMIT_DEC_NEG : LIMIT_DEC_POS);
  // acc * 16 or acc * 10 as shifts and one add
  assign prod  = cur_i.hex ? {cur_i.acc, 4'b0000}
                           : ({1'b0, cur_i.acc, 3'b000} + {3'b000, cur_i.acc, 1'b0});
  assign sum     = prod + PROD_W'(digit);
  assign dig_bad = digit >= base;

  always_comb begin
    nxt      = cur_i;
    take_dig = 1'b0;
    if (req_i.has_char && !cur_i.failed) begin
      unique case (cur_i.phase) inside
        PH_SPACE, PH_BASE: begin
          if (cur_i.phase == PH_SPACE && c == CH_SPACE) begin
            nxt = cur_i;
          end else if (cur_i.phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
            nxt.neg   = (c == CH_MINUS);
            nxt.phase = PH_BASE;
          end else if (c == CH_DOLLAR) begin
            nxt.hex   = 1'b1;
            nxt.phase = PH_DIGITS;
          end else if (c == CH_ZERO) begin
            nxt.acc   = '0;
            nxt.seen  = 1'b1;
            nxt.phase = PH_ZERO;
          end else begin
            take_dig = 1'b1;
          end
        end
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            nxt.hex   = 1'b1;
            nxt.seen  = 1'b0;
            nxt.acc   = '0;
            nxt.phase = PH_DIGITS;
          end else begin
            take_dig = 1'b1;
          end
        end
        PH_DIGITS: take_dig = 1'b1;
        default:   take_dig = 1'b1;
      endcase
      if (take_dig) begin
        nxt.phase = PH_DIGITS;
        if (dig_bad) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.acc  = sum[ACC_W-1:0];
          nxt.seen = 1'b1;
          if (sum > limit) begin
            nxt.failed = 1'b1;
          end
        end
      end
    end
  end

  assign fail = nxt.failed || nxt.phase == PH_SPACE || nxt.phase == PH_BASE || !nxt.seen;

  // Hex wraps into the signed 32-bit range; decimal stays below 2^31 + 1
  assign mag = nxt.hex ? {nxt.acc[31], nxt.acc[31:0]} : nxt.acc;
  assign val = VAL_W'(mag);

  assign nxt_o              = nxt;
  assign rsp_o.used_fallback = fail;
  assign rsp_o.result_value  = fail ? req_i.fallback_value
                             : (nxt.neg ? (VAL_W'(0) - val) : val);

endmodule

`default_nettype wire

@@ rtl/core/dhp_checker.sv @@
// Port-level checker for the text parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_hex_integer_text_parser_top_assert.svh"

module dhp_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input dhp_pkg::dhp_in_t  in_req_i,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input dhp_pkg::dhp_out_t out_rsp_o
);
  import dhp_pkg::*;

  // Negating a wrapped hex minimum gives +2^31, so allow 33 signed bits
  logic [VAL_W-33:0] hi_bits;

  assign hi_bits = out_rsp_o.result_value[VAL_W-1:32];

  `DHP_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_req_i),
    "request dropped or changed while stalled")
  `DHP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o,
    "response dropped while stalled")
  `DHP_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_rsp_o),
    "response changed while stalled")
  `DHP_ASSERT(a_stall_cause, !in_ready_o |-> (out_valid_o && !out_ready_i),
    "request stalled without a held response")
  `DHP_ASSERT(a_range, (out_valid_o && !out_rsp_o.used_fallback)
    |-> (hi_bits == '0 || hi_bits == '1),
    "parsed value outside the signed 33-bit range")

endmodule

bind decimal_hex_integer_text_parser_top dhp_checker u_dhp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the decimal/hex integer text parser.
`timescale 1ns / 1ps

module tb;
  import dhp_pkg::*;

  // Subtracted from a hex magnitude above the positive decimal limit.
  localparam logic signed [VAL_W-1:0] WRAP_SPAN = 64'sh1_0000_0000;
  localparam int MAX_REPORTS = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  dhp_in_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dhp_out_t out_rsp;

  decimal_hex_integer_text_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle and stall odds in percent; characters with no code point mixed in.
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int gap_char_pct    = 0;
  int chars_sent      = 0;
  int error_count     = 0;

  dhp_out_t parse_results_due[$];
  dhp_in_t  text_items[$];

  // Parser state as the block should hold it.
  dhp_phase_e       prs_phase  = PH_SPACE;
  logic             prs_neg    = 1'b0;
  logic             prs_hex    = 1'b0;
  logic [ACC_W-1:0] prs_acc    = '0;
  logic             prs_failed = 1'b0;
  logic             prs_seen   = 1'b0;

  function automatic logic [4:0] digit_value(input logic [CP_W-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A) + 5'd10;
    if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A) + 5'd10;
    return DIGIT_NONE;
  endfunction

  // Accumulate one digit; a digit outside the base or an overflow marks failure.
  task automatic absorb_digit(input logic [CP_W-1:0] c);
    logic [4:0]        base;
    logic [4:0]        d;
    logic [PROD_W-1:0] limit;
    logic [PROD_W-1:0] prod;
    base  = prs_hex ? BASE_HEX : BASE_DEC;
    limit = prs_hex ? LIMIT_HEX : (prs_neg ? LIMIT_DEC_NEG : LIMIT_DEC_POS);
    d     = digit_value(c);
    prs_phase = PH_DIGITS;
    if (d >= base) begin
      prs_failed = 1'b1;
    end else begin
      prod     = PROD_W'(prs_acc) * PROD_W'(base) + PROD_W'(d);
      prs_acc  = prod[ACC_W-1:0];
      prs_seen = 1'b1;
      if (prod > limit) prs_failed = 1'b1;
    end
  endtask

  // First character after spaces and sign: '$' selects hex, '0' may start "0x".
  task automatic absorb_base_char(input logic [CP_W-1:0] c);
    if (c == CH_DOLLAR) begin
      prs_hex   = 1'b1;
      prs_phase = PH_DIGITS;
    end else if (c == CH_ZERO) begin
      prs_acc   = '0;
      prs_seen  = 1'b1;
      prs_phase = PH_ZERO;
    end else begin
      absorb_digit(c);
    end
  endtask

  // Advance the expected parser by one request; queue a response on last.
  task automatic predict_parse_step(input dhp_in_t req);
    logic [CP_W-1:0]         c;
    logic signed [VAL_W-1:0] v;
    dhp_out_t                rsp;
    c = req.code_point;
    if (req.has_char && !prs_failed) begin
      case (prs_phase)
        PH_SPACE: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            prs_neg   = (c == CH_MINUS);
            prs_phase = PH_BASE;
          end else if (c != CH_SPACE) begin
            absorb_base_char(c);
          end
        end
        PH_BASE: begin
          absorb_base_char(c);
        end
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            prs_hex   = 1'b1;
            prs_seen  = 1'b0;
            prs_acc   = '0;
            prs_phase = PH_DIGITS;
          end else begin
            absorb_digit(c);
          end
        end
        default: begin
          absorb_digit(c);
        end
      endcase
    end
    if (req.last) begin
      if (prs_failed || prs_phase == PH_SPACE || prs_phase == PH_BASE || !prs_seen) begin
        rsp.result_value  = req.fallback_value;
        rsp.used_fallback = 1'b1;
      end else begin
        v = $signed({{(VAL_W-ACC_W){1'b0}}, prs_acc});
        if (prs_hex && v > $signed(VAL_W'(LIMIT_DEC_POS))) v = v - WRAP_SPAN;
        if (prs_neg) v = -v;
        rsp.result_value  = v;
        rsp.used_fallback = 1'b0;
      end
      parse_results_due.push_back(rsp);
      // every string starts from a clean parser
      prs_phase  = PH_SPACE;
      prs_neg    = 1'b0;
      prs_hex    = 1'b0;
      prs_acc    = '0;
      prs_failed = 1'b0;
      prs_seen   = 1'b0;
    end
  endtask

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Compare every taken response with the oldest expected one.
  always @(posedge clk) begin : check_response
    dhp_out_t exp_rsp;
    if (rst_n && out_valid && out_ready) begin
      if (parse_results_due.size() == 0) begin
        note_failure($sformatf("unexpected response value=%0d fallback=%0b",
                               out_rsp.result_value, out_rsp.used_fallback));
      end else begin
        exp_rsp = parse_results_due.pop_front();
        if (out_rsp.result_value !== exp_rsp.result_value)
          note_failure($sformatf("result_value expected %0d got %0d",
                                 exp_rsp.result_value, out_rsp.result_value));
        if (out_rsp.used_fallback !== exp_rsp.used_fallback)
          note_failure($sformatf("used_fallback expected %0b got %0b",
                                 exp_rsp.used_fallback, out_rsp.used_fallback));
      end
    end
  end

  // Receiver: stall at random, re-decided every cycle.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // Send one request: idle at random first, then hold valid until taken.
  task automatic send_request(input dhp_in_t req);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_req   = req;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (req.has_char) chars_sent++;
    predict_parse_step(req);
  endtask

  function automatic void add_no_char();
    dhp_in_t item;
    item.code_point     = CP_W'($urandom);
    item.has_char       = 1'b0;
    item.last           = 1'b0;
    item.fallback_value = {$urandom, $urandom};
    text_items.push_back(item);
  endfunction

  function automatic void add_code_point(input logic [CP_W-1:0] cp);
    dhp_in_t item;
    if ($urandom_range(99) < gap_char_pct) add_no_char();
    item.code_point     = cp;
    item.has_char       = 1'b1;
    item.last           = 1'b0;
    item.fallback_value = {$urandom, $urandom};
    text_items.push_back(item);
  endfunction

  function automatic void add_chars(input string s);
    for (int i = 0; i < s.len(); i++) add_code_point(CP_W'(s[i]));
  endfunction

  // Mark the end of the queued string, send it all and empty the queue.
  task automatic send_text(input logic signed [VAL_W-1:0] fallback);
    int n;
    if (text_items.size() == 0) add_no_char();
    n = text_items.size() - 1;
    text_items[n].last           = 1'b1;
    text_items[n].fallback_value = fallback;
    foreach (text_items[i]) send_request(text_items[i]);
    text_items.delete();
  endtask

  // Drop valid and hold until every expected response is back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (parse_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Build one string: mostly well-formed numbers near the limits, some broken.
  task automatic build_random_text();
    logic [63:0] mag;
    logic [3:0]  digs[$];
    int          form;
    int          flaw;
    int          n;
    bit          broken;
    logic [CP_W-1:0] cp;
    broken = ($urandom_range(99) < 25);
    flaw   = $urandom_range(3);
    repeat ($urandom_range(2)) add_code_point(CH_SPACE);
    if ($urandom_range(19) != 0) begin
      case ($urandom_range(2))
        1: add_code_point(CH_PLUS);
        2: add_code_point(CH_MINUS);
        default: ;
      endcase
      // space after the sign
      if (broken && flaw == 2) add_code_point(CH_SPACE);
      // forms: 0 and 1 decimal, 2 dollar prefix, 3 zero-x prefix
      form = $urandom_range(3);
      if (form == 2) begin
        add_code_point(CH_DOLLAR);
      end else if (form == 3) begin
        add_code_point(CH_ZERO);
        add_code_point($urandom_range(1) ? CH_UP_X : CH_LO_X);
      end
      if (form >= 2) begin
        case ($urandom_range(7))
          0: mag = $urandom_range(15);
          1: mag = 64'h7FFF_FFFF;
          2: mag = 64'h8000_0000;
          3: mag = 64'hFFFF_FFFF;
          4: mag = 64'h1_0000_0000;
          5: mag = {32'd0, $urandom};
          6: mag = $urandom_range(16'hFFFF);
          default: mag = {31'd0, 1'b1, $urandom};
        endcase
      end else begin
        case ($urandom_range(7))
          0: mag = $urandom_range(9);
          1: mag = $urandom_range(99999);
          2: mag = 64'h7FFF_FFFF;
          3: mag = 64'h8000_0000;
          4: mag = 64'h8000_0001;
          5: mag = {32'd0, $urandom};
          6: mag = $urandom_range(32'h7FFF_FFFF);
          default: mag = {30'd0, 2'($urandom_range(3)), $urandom};
        endcase
      end
      do begin
        if (form >= 2) begin
          digs.push_front(mag[3:0]);
          mag = mag >> 4;
        end else begin
          digs.push_front(4'(mag % 10));
          mag = mag / 10;
        end
      end while (mag != 0);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) digs.push_front(4'd0);
      // a prefix with no digits behind it
      if (!(broken && flaw == 3)) begin
        foreach (digs[i]) begin
          if (digs[i] < 10) cp = CH_ZERO + CP_W'(digs[i]);
          else cp = ($urandom_range(1) ? CH_UP_A : CH_LO_A) + CP_W'(digs[i] - 10);
          add_code_point(cp);
        end
      end
      // overwrite one character with any code point or printable ASCII
      if (broken && flaw < 2 && text_items.size() != 0) begin
        n = $urandom_range(text_items.size() - 1);
        text_items[n].has_char   = 1'b1;
        text_items[n].code_point = (flaw == 0) ? CP_W'($urandom)
                                               : CP_W'($urandom_range(32, 126));
      end
    end
    if ($urandom_range(9) == 0) add_no_char();
  endtask

  task automatic test_blank_strings();
    send_text(64'sh8000_0000_0000_0000);
    add_chars(" ");
    send_text(64'sh7FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_zero_and_prefixes();
    add_chars("0");
    send_text({$urandom, $urandom});
    add_chars("-0X");
    send_text(-64'sd1);
    add_chars("$");
    send_text(64'sd0);
    add_chars("07");
    send_text({$urandom, $urandom});
  endtask

  task automatic test_sign_space_and_gaps();
    add_chars("+ ");
    send_text({$urandom, $urandom});
    add_chars(" ");
    add_no_char();
    add_chars("5");
    send_text({$urandom, $urandom});
  endtask

  task automatic test_bad_characters();
    add_code_point(CP_W'(32'h1F_FFFF));
    send_text({$urandom, $urandom});
    add_chars("9a");
    send_text({$urandom, $urandom});
  endtask

  task automatic test_hex_wrap();
    add_chars("$FFFFFFFF");
    send_text({$urandom, $urandom});
  endtask

  task automatic test_random_strings(input int idle, input int stall, input int count);
    int target;
    logic signed [VAL_W-1:0] fallback;
    sender_idle_pct = idle;
    stall_pct       = stall;
    gap_char_pct    = 8;
    target          = chars_sent + count;
    while (chars_sent < target) begin
      case ($urandom_range(7))
        0: fallback = 64'sh8000_0000_0000_0000;
        1: fallback = 64'sh7FFF_FFFF_FFFF_FFFF;
        2: fallback = 64'sd0;
        default: fallback = {$urandom, $urandom};
      endcase
      build_random_text();
      send_text(fallback);
    end
    // pause the sender until the block has drained
    wait_for_results();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_blank_strings();
    test_zero_and_prefixes();
    test_sign_space_and_gaps();
    test_bad_characters();
    test_hex_wrap();
    wait_for_results();

    test_random_strings(0, 0, 320);
    test_random_strings(85, 0, 310);
    test_random_strings(0, 85, 310);
    test_random_strings(18, 18, 310);

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #6000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/dhp_pkg.sv
rtl/core/dhp_step.sv
rtl/core/decimal_hex_integer_text_parser_top.sv
rtl/core/dhp_checker.sv
bench/tb.sv
